FILE: rtl/hti_pkg.sv
// Package: constants, memory entry types and sequencer states for the intersection unit.
`timescale 1ns / 1ps
`default_nettype none
package hti_pkg;
  localparam int STORE_DEPTH   = 4096;
  localparam int IDX_W         = $clog2(STORE_DEPTH);
  localparam int CNT_W         = IDX_W + 1;
  localparam int BUCKET_SLOTS  = 15;
  localparam int SLOT_W        = 4;
  localparam int HASH_BITS     = 22;
  localparam int ELEMENT_WORDS = 8;
  localparam int WORD_W        = 64;
  localparam int WSEL_W        = 3;
  localparam int KEY_W         = ELEMENT_WORDS * WORD_W;
  localparam int SLICE_BITS    = 21;
  localparam int SLICE_COUNT   = 24;
  localparam int SLICE_CNT_W   = 5;
  localparam int TOP_BIT_POS   = 496;
  localparam int NUM_BUCKETS   = 1 << HASH_BITS;
  localparam int ESTORE_DEPTH  = STORE_DEPTH * ELEMENT_WORDS;
  localparam int ESTORE_AW     = IDX_W + WSEL_W;
  localparam int OUT_IDX_W     = 12;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_PROBE  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_BUCKET_FULL = 2'd1;
  localparam logic [1:0] ST_STORE_FULL  = 2'd2;

  typedef struct packed {
    logic [IDX_W-1:0]  first;
    logic [IDX_W-1:0]  tail;
    logic [SLOT_W-1:0] count;
  } bucket_t;

  typedef struct packed {
    logic [HASH_BITS-1:0] hash;
    logic                 head;
  } meta_t;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_HASH  = 9'b000000010,
    S_BRD   = 9'b000000100,
    S_META  = 9'b000001000,
    S_DEC   = 9'b000010000,
    S_WRITE = 9'b000100000,
    S_PCMP  = 9'b001000000,
    S_DONE  = 9'b010000000,
    S_SPARE = 9'b100000000
  } state_t;
endpackage
`default_nettype wire

FILE: rtl/hti_hash.sv
// Serial slice hash: one 21-bit slice added per cycle through a shared adder.
`timescale 1ns / 1ps
`default_nettype none
module hti_hash (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          load,
  input  wire logic [hti_pkg::KEY_W-1:0]     key_in,
  output logic                               done,
  output logic [hti_pkg::HASH_BITS-1:0]      hash
);
  import hti_pkg::*;

  logic [KEY_W-1:0]       sr;
  logic [SLICE_BITS-1:0]  sum;
  logic [SLICE_CNT_W-1:0] cnt;
  logic                   run;
  logic                   top;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (load) begin
        run <= 1'b1;
      end else if (run && cnt == SLICE_CNT_W'(SLICE_COUNT - 1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sr  <= key_in;
      sum <= '0;
      cnt <= '0;
      top <= key_in[TOP_BIT_POS];
    end else if (run) begin
      sum <= sum + sr[SLICE_BITS-1:0];
      sr  <= sr >> SLICE_BITS;
      cnt <= cnt + 1'b1;
    end
  end

  assign hash = {top, sum};
endmodule
`default_nettype wire

FILE: rtl/hash_table_intersection_unit.sv
// Top level: sequencer, bucket/chain/element memories and word-serial compare.
// Request flow: clear, unknown command and full store go straight to the result strobe; insert
// runs 24 hash steps, bucket and head lookups, then 8 element word writes; full bucket stops
// after the lookups; probe scans bucket entries through the one-word-per-cycle element store port.
// One request at a time: busy stays high until the result strobe; the receiver cannot stall.
// Reset clears the sequencer and element counter; no memory clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module hash_table_intersection_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [1:0]                          command,
  input  wire logic [hti_pkg::WORD_W-1:0]          key_word_0,
  input  wire logic [hti_pkg::WORD_W-1:0]          key_word_1,
  input  wire logic [hti_pkg::WORD_W-1:0]          key_word_2,
  input  wire logic [hti_pkg::WORD_W-1:0]          key_word_3,
  input  wire logic [hti_pkg::WORD_W-1:0]          key_word_4,
  input  wire logic [hti_pkg::WORD_W-1:0]          key_word_5,
  input  wire logic [hti_pkg::WORD_W-1:0]          key_word_6,
  input  wire logic [hti_pkg::WORD_W-1:0]          key_word_7,
  output logic                                     strobe,
  output logic [1:0]                               status,
  output logic                                     matched,
  output logic [hti_pkg::OUT_IDX_W-1:0]            match_index
);
  import hti_pkg::*;

  state_t               state;
  logic [1:0]           cmd;
  logic [KEY_W-1:0]     key;
  logic [HASH_BITS-1:0] h;
  logic [CNT_W-1:0]     counter;
  bucket_t              bucket_q;
  meta_t                meta_q;
  logic [WORD_W-1:0]    elem_q;
  logic [IDX_W-1:0]     nxt_q;
  logic [IDX_W-1:0]     t;
  logic [SLOT_W-1:0]    rem;
  logic [SLOT_W-1:0]    wc;
  logic                 eq;
  logic                 hash_done;
  logic [HASH_BITS-1:0] hash_out;
  logic                 accept;
  logic                 bvalid;
  logic [WSEL_W-1:0]    csel;
  logic                 word_eq;
  logic                 bucket_we;
  bucket_t              bucket_wd;
  logic                 ins_ok;

  bucket_t           bucket_mem [NUM_BUCKETS];
  meta_t             meta_mem   [STORE_DEPTH];
  logic [IDX_W-1:0]  next_mem   [STORE_DEPTH];
  logic [WORD_W-1:0] elem_mem   [ESTORE_DEPTH];

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);
  assign strobe = (state == S_DONE);

  hti_hash u_hash (
    .clk    (clk),
    .rst    (rst),
    .load   (accept),
    .key_in ({key_word_7, key_word_6, key_word_5, key_word_4,
              key_word_3, key_word_2, key_word_1, key_word_0}),
    .done   (hash_done),
    .hash   (hash_out)
  );

  // bucket is live only if its head element belongs to the current fill
  assign bvalid = ({1'b0, bucket_q.first} < counter) && (meta_q.hash == h) && meta_q.head;
  assign ins_ok = !(bvalid && bucket_q.count == SLOT_W'(BUCKET_SLOTS));
  assign csel    = wc[WSEL_W-1:0] - 1'b1;
  assign word_eq = (elem_q == key[csel*WORD_W +: WORD_W]);

  always_comb begin
    bucket_we = (state == S_DEC) && (cmd == CMD_INSERT) && ins_ok;
    if (bvalid) begin
      bucket_wd = '{first: bucket_q.first, tail: counter[IDX_W-1:0],
                    count: bucket_q.count + 1'b1};
    end else begin
      bucket_wd = '{first: counter[IDX_W-1:0], tail: counter[IDX_W-1:0],
                    count: SLOT_W'(1)};
    end
  end

  always_ff @(posedge clk) begin
    if (bucket_we) begin
      bucket_mem[h] <= bucket_wd;
    end
    if (state == S_BRD) begin
      bucket_q <= bucket_mem[h];
    end
  end

  always_ff @(posedge clk) begin
    if (bucket_we) begin
      meta_mem[counter[IDX_W-1:0]] <= '{hash: h, head: !bvalid};
    end
    if (state == S_META) begin
      meta_q <= meta_mem[bucket_q.first];
    end
  end

  always_ff @(posedge clk) begin
    if (bucket_we && bvalid) begin
      next_mem[bucket_q.tail] <= counter[IDX_W-1:0];
    end
    if (state == S_PCMP && wc == '0) begin
      nxt_q <= next_mem[t];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_WRITE) begin
      elem_mem[{counter[IDX_W-1:0], wc[WSEL_W-1:0]}] <=
        key[wc[WSEL_W-1:0]*WORD_W +: WORD_W];
    end
    if (state == S_PCMP) begin
      elem_q <= elem_mem[{t, wc[WSEL_W-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      counter <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd         <= command;
            key         <= {key_word_7, key_word_6, key_word_5, key_word_4,
                            key_word_3, key_word_2, key_word_1, key_word_0};
            status      <= (command == CMD_INSERT && counter == CNT_W'(STORE_DEPTH)) ?
                           ST_STORE_FULL : ST_OK;
            matched     <= 1'b0;
            match_index <= '0;
            case (command)
              CMD_INSERT: begin
                if (counter == CNT_W'(STORE_DEPTH)) begin
                  state <= S_DONE;
                end else begin
                  state <= S_HASH;
                end
              end
              CMD_PROBE: state <= S_HASH;
              CMD_CLEAR: begin
                counter <= '0;
                state   <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_HASH: begin
          if (hash_done) begin
            h     <= hash_out;
            state <= S_BRD;
          end
        end
        S_BRD:  state <= S_META;
        S_META: state <= S_DEC;
        S_DEC: begin
          wc <= '0;
          eq <= 1'b1;
          if (cmd == CMD_INSERT) begin
            if (ins_ok) begin
              state <= S_WRITE;
            end else begin
              status <= ST_BUCKET_FULL;
              state  <= S_DONE;
            end
          end else if (bvalid) begin
            t     <= bucket_q.first;
            rem   <= bucket_q.count;
            state <= S_PCMP;
          end else begin
            state <= S_DONE;
          end
        end
        S_WRITE: begin
          wc <= wc + 1'b1;
          if (wc == SLOT_W'(ELEMENT_WORDS - 1)) begin
            counter <= counter + 1'b1;
            state   <= S_DONE;
          end
        end
        S_PCMP: begin
          if (wc == SLOT_W'(ELEMENT_WORDS)) begin
            wc <= '0;
            eq <= 1'b1;
            if (eq && word_eq) begin
              matched     <= 1'b1;
              match_index <= OUT_IDX_W'(t);
              state       <= S_DONE;
            end else if (rem == SLOT_W'(1)) begin
              state <= S_DONE;
            end else begin
              rem <= rem - 1'b1;
              t   <= nxt_q;
            end
          end else begin
            if (wc != '0) begin
              eq <= eq & word_eq;
            end
            wc <= wc + 1'b1;
          end
        end
        S_DONE:  state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe && !busy) else $error("result strobe longer than one cycle");
  a_counter_range: assert property (@(posedge clk) disable iff (rst)
    counter <= CNT_W'(STORE_DEPTH)) else $error("element counter beyond store depth");
  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_PCMP |-> rem != '0) else $error("bucket scan with no entries left");
  a_counter_step: assert property (@(posedge clk) disable iff (rst)
    counter != $past(counter) && $past(cmd) != CMD_CLEAR |-> state == S_DONE)
    else $error("element counter moved outside an insert");
endmodule
`default_nettype wire
